// ===== rtl/mvf_pkg.sv =====
// Shared types, constants and helpers for the masked multiply-add lane.
// No dependencies.
package mvf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DepthDefault = 2;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [31:0] ExpMask = 32'h7F80_0000;

  // Special-case outcome carried from decode to pack.
  typedef struct packed {
    logic        bypass;  // result fully known, no rounding needed
    logic [31:0] value;
  } spec_t;

  // Unrounded value: sign * mag * 2^(scale), mag below 2^58.
  typedef struct packed {
    logic        sign;
    logic signed [10:0] scale;
    logic [57:0] mag;
  } raw_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > ExpMask[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:0] == ExpMask[30:0];
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // Leading-one position of a 58-bit value.
  function automatic logic [5:0] lead_one(input logic [57:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 58; i++) begin
      if (m[i]) n = 6'(i);
    end
    return n;
  endfunction

  // Round sign * mag * 2^s to binary32, nearest-even.
  function automatic logic [31:0] round_pack(input raw_t r);
    logic [5:0] n;
    logic signed [12:0] sh;
    logic signed [12:0] lim;
    logic signed [12:0] qe;
    logic [57:0] q;
    logic [57:0] rem;
    logic [57:0] half;
    logic signed [12:0] be;
    n = lead_one(r.mag);
    sh = 13'(n) - 13'sd23;
    lim = -13'sd149 - 13'(r.scale);
    if (lim > sh) sh = lim;
    qe = 13'(r.scale) + sh;
    q = 58'd0;
    if (sh <= 0) begin
      q = r.mag << 6'(-sh);
    end else if (sh < 58) begin
      rem = r.mag & ((58'd1 << 6'(sh)) - 58'd1);
      half = 58'd1 << 6'(sh - 1);
      q = r.mag >> 6'(sh);
      if (rem > half || (rem == half && q[0])) q = q + 58'd1;
    end
    if (q == (58'd1 << 24)) begin
      q = q >> 1;
      qe = qe + 13'sd1;
    end
    be = qe + 13'sd150;
    if (q == 58'd0) return {r.sign, 31'd0};
    if (q[23]) begin
      if (be >= 255) return {r.sign, ExpMask[30:0]};
      return {r.sign, be[7:0], q[22:0]};
    end
    return {r.sign, 8'd0, q[22:0]};
  endfunction

endpackage

// ===== rtl/mvf_mul.sv =====
// Multiply stage: decode and significand product, registered unrounded; the top level rounds it.
// Depends on mvf_pkg.
module mvf_mul import mvf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output raw_t        raw_o,
  output spec_t       spec_o
);
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic signed [10:0] qa, qb;
  raw_t  raw_d;
  spec_t spec_d;
  logic  sgn;

  always_comb begin
    sgn = a_i[31] ^ b_i[31];
    ma = (a_i[30:23] == 8'd0) ? {1'b0, a_i[22:0]} : {1'b1, a_i[22:0]};
    mb = (b_i[30:23] == 8'd0) ? {1'b0, b_i[22:0]} : {1'b1, b_i[22:0]};
    qa = (a_i[30:23] == 8'd0) ? -11'sd149 : 11'($signed({3'b0, a_i[30:23]})) - 11'sd150;
    qb = (b_i[30:23] == 8'd0) ? -11'sd149 : 11'($signed({3'b0, b_i[30:23]})) - 11'sd150;
    // full 48-bit significand product
    prod = 48'(ma) * 48'(mb);
    raw_d.sign = sgn;
    raw_d.scale = qa + qb;
    raw_d.mag = {10'd0, prod};
    spec_d.bypass = 1'b1;
    priority if (is_nan(a_i)) spec_d.value = a_i | QuietBit;
    else if (is_nan(b_i)) spec_d.value = b_i | QuietBit;
    else if (is_inf(a_i)) spec_d.value = is_zero(b_i) ? DefaultNan : {sgn, ExpMask[30:0]};
    else if (is_inf(b_i)) spec_d.value = is_zero(a_i) ? DefaultNan : {sgn, ExpMask[30:0]};
    else if (is_zero(a_i) || is_zero(b_i)) spec_d.value = {sgn, 31'd0};
    else begin
      spec_d.bypass = 1'b0;
      spec_d.value = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_o  <= raw_d;
      spec_o <= spec_d;
    end
  end
  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

// ===== rtl/mvf_add.sv =====
// Add stage: aligns the rounded product with the addend into an unrounded sum.
// Depends on mvf_pkg.
module mvf_add import mvf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output raw_t        raw_o,
  output spec_t       spec_o
);
  logic [31:0] bx, by;
  logic [23:0] mx, my;
  logic signed [10:0] qx, qy;
  logic [8:0] d;
  logic [57:0] big, sml;
  raw_t  raw_d;
  spec_t spec_d;

  always_comb begin
    if (x_i[30:0] < y_i[30:0]) begin
      bx = y_i; by = x_i;
    end else begin
      bx = x_i; by = y_i;
    end
    mx = (bx[30:23] == 8'd0) ? {1'b0, bx[22:0]} : {1'b1, bx[22:0]};
    my = (by[30:23] == 8'd0) ? {1'b0, by[22:0]} : {1'b1, by[22:0]};
    qx = (bx[30:23] == 8'd0) ? -11'sd149 : 11'($signed({3'b0, bx[30:23]})) - 11'sd150;
    qy = (by[30:23] == 8'd0) ? -11'sd149 : 11'($signed({3'b0, by[30:23]})) - 11'sd150;
    d = 9'(qx - qy);
    big = {2'd0, mx, 32'd0};
    if (d <= 9'd32) sml = {34'd0, my} << (6'd32 - 6'(d));
    else if (d - 9'd32 >= 9'd24) sml = 58'd1;
    else sml = ({34'd0, my} >> 5'(d - 9'd32)) | 58'd1;
    raw_d.sign = bx[31];
    raw_d.scale = qx - 11'sd32;
    raw_d.mag = (bx[31] ^ by[31]) ? big - sml : big + sml;
    spec_d.bypass = 1'b1;
    priority if (is_nan(x_i)) spec_d.value = x_i | QuietBit;
    else if (is_nan(y_i)) spec_d.value = y_i | QuietBit;
    else if (is_inf(x_i))
      spec_d.value = (is_inf(y_i) && (x_i[31] ^ y_i[31])) ? DefaultNan : x_i;
    else if (is_inf(y_i)) spec_d.value = y_i;
    else if (is_zero(x_i) && is_zero(y_i)) spec_d.value = x_i & y_i;
    else if (is_zero(x_i)) spec_d.value = y_i;
    else if (is_zero(y_i)) spec_d.value = x_i;
    else if (raw_d.mag == 58'd0) spec_d.value = 32'd0;
    else begin
      spec_d.bypass = 1'b0;
      spec_d.value = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_o  <= raw_d;
      spec_o <= spec_d;
    end
  end
endmodule

// ===== rtl/masked_vector_fmadd_lane.sv =====
// Top level of the masked single-precision multiply-add lane.
// Depends on mvf_pkg, mvf_mul and mvf_add.
//
// One lane per transfer, a new lane every cycle unless the output stalls.
// Stages: S1 product registered, S2 product rounded, S3 aligned sum
// registered, S4 sum rounded into the output register. The rate
// is set by the single-issue pipeline; a stall holds every stage in place
// (global enable), so the input stays ready while the output register is
// empty or being taken. Unfused: the product rounds to nearest-even, then
// the sum rounds again. Masked lanes carry the merge value or +0.0.
module masked_vector_fmadd_lane import mvf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] factor_a_i,
  input  logic [31:0] factor_b_i,
  input  logic [31:0] addend_c_i,
  input  logic [31:0] merge_value_i,
  input  logic        lane_active_i,
  input  logic        merge_enable_i,
  input  logic        last_lane_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] lane_result_o,
  output logic        result_last_o
);
  // sideband carried along the pipe
  typedef struct packed {
    logic        active;
    logic [31:0] alt;   // value for a masked lane
    logic        last;
    logic [31:0] c;
  } side_t;

  logic [3:0] vld_q;
  logic       en;
  side_t side_d, s1_q, s2_q, s3_q;
  raw_t  mraw, araw;
  spec_t mspec, aspec;
  logic [31:0] prod_q, res_d, res_q;
  logic        last_q;

  assign en = !vld_q[3] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[3];
  assign lane_result_o = res_q;
  assign result_last_o = last_q;

  assign side_d = '{active: lane_active_i,
                    alt: merge_enable_i ? merge_value_i : 32'd0,
                    last: last_lane_i, c: addend_c_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  mvf_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .a_i(factor_a_i), .b_i(factor_b_i),
    .raw_o(mraw), .spec_o(mspec)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= side_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
      prod_q <= mspec.bypass ? mspec.value : round_pack(mraw);
      res_q <= res_d;
      last_q <= s3_q.last;
    end
  end

  mvf_add u_add (
    .clk_i, .en_i(en), .x_i(prod_q), .y_i(s2_q.c),
    .raw_o(araw), .spec_o(aspec)
  );

  always_comb begin
    if (!s3_q.active) res_d = s3_q.alt;
    else if (aspec.bypass) res_d = aspec.value;
    else res_d = round_pack(araw);
  end
endmodule

// ===== rtl/mvf_checker.sv =====
// Port-level checker for the multiply-add lane, bound to the top level.
// Depends on mvf_pkg only by convention; sees ports alone.
module mvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] lane_result_o,
  input logic        result_last_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lane_result_o)
    && $stable(result_last_o)) else $error("output changed while stalled");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("stalled with empty output");
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o) else $error("ready during stall");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o) else $error("valid in reset");
endmodule

bind masked_vector_fmadd_lane mvf_checker u_chk (.*);

// ===== tb/sv/tb.sv =====
// Testbench for masked_vector_fmadd_lane: directed and random lanes checked
// against an in-bench binary32 multiply-then-add predictor (two roundings).
// Depends on the RTL top level only.
`timescale 1ns / 100ps

// Expected-lane store and comparison. Holds its own binary32 predictor.
class fmadd_scoreboard;
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } lane_t;

  lane_t pending[$];
  int    mismatches;
  int    lanes_checked;

  function automatic logic nan32(logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction
  function automatic logic inf32(logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction
  function automatic logic zero32(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // Significand and quantum exponent: x = sig * 2^qexp.
  function automatic void unpack32(logic [31:0] x, output logic [63:0] sig,
                                   output int qexp);
    if (x[30:23] == 8'd0) begin
      sig = {41'd0, x[22:0]};
      qexp = -149;
    end else begin
      sig = {40'd0, 1'b1, x[22:0]};
      qexp = int'(x[30:23]) - 150;
    end
  endfunction

  // Round sign * mag * 2^s to nearest-even binary32.
  function automatic logic [31:0] round32(logic sgn, int s, logic [63:0] mag);
    int msb, sh, qe;
    logic [63:0] q, rem, half;
    msb = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    sh = msb - 23;
    if (-149 - s > sh) sh = -149 - s;
    qe = s + sh;
    if (sh <= 0) q = mag << (-sh);
    else if (sh >= 60) q = 64'd0;
    else begin
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    if (q == (64'd1 << 24)) begin
      q = q >> 1;
      qe++;
    end
    if (q == 64'd0) return {sgn, 31'd0};
    if (q[23]) begin
      if (qe + 150 >= 255) return {sgn, 31'h7F80_0000};
      return {sgn, 8'(qe + 150), q[22:0]};
    end
    return {sgn, 8'd0, q[22:0]};
  endfunction

  function automatic logic [31:0] product32(logic [31:0] a, logic [31:0] b);
    logic sgn;
    logic [63:0] ma, mb;
    int qa, qb;
    sgn = a[31] ^ b[31];
    if (nan32(a)) return a | 32'h0040_0000;
    if (nan32(b)) return b | 32'h0040_0000;
    if (inf32(a)) return zero32(b) ? 32'hFFC0_0000 : {sgn, 31'h7F80_0000};
    if (inf32(b)) return zero32(a) ? 32'hFFC0_0000 : {sgn, 31'h7F80_0000};
    if (zero32(a) || zero32(b)) return {sgn, 31'd0};
    unpack32(a, ma, qa);
    unpack32(b, mb, qb);
    return round32(sgn, qa + qb, ma * mb);
  endfunction

  function automatic logic [31:0] sum32(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    logic [63:0] mx, my, big, sml;
    int qx, qy, d;
    if (nan32(x)) return x | 32'h0040_0000;
    if (nan32(y)) return y | 32'h0040_0000;
    if (inf32(x)) begin
      if (inf32(y) && (x[31] != y[31])) return 32'hFFC0_0000;
      return x;
    end
    if (inf32(y)) return y;
    if (zero32(x) && zero32(y)) return x & y;
    if (zero32(x)) return y;
    if (zero32(y)) return x;
    if (x[30:0] < y[30:0]) begin
      t = x; x = y; y = t;
    end
    unpack32(x, mx, qx);
    unpack32(y, my, qy);
    d = qx - qy;
    big = mx << 32;
    if (d <= 32) sml = my << (32 - d);
    else begin
      sml = (d - 32 >= 64) ? 64'd0 : (my >> (d - 32));
      sml[0] = 1'b1;
    end
    if (x[31] != y[31]) begin
      if (big == sml) return 32'd0;
      return round32(x[31], qx - 32, big - sml);
    end
    return round32(x[31], qx - 32, big + sml);
  endfunction

  function void note_lane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [31:0] src, logic act, logic mrg, logic lst);
    lane_t e;
    e.value = act ? sum32(product32(a, b), c) : (mrg ? src : 32'd0);
    e.last = lst;
    pending.push_back(e);
  endfunction

  function void check_lane(logic [31:0] value, logic last);
    lane_t e;
    lanes_checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h last %b", value, last);
      return;
    end
    e = pending.pop_front();
    if (e.value !== value || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h/%b got %h/%b", e.value, e.last, value, last);
    end
  endfunction
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] factor_a_i = '0;
  logic [31:0] factor_b_i = '0;
  logic [31:0] addend_c_i = '0;
  logic [31:0] merge_value_i = '0;
  logic        lane_active_i = 1'b0;
  logic        merge_enable_i = 1'b0;
  logic        last_lane_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] lane_result_o;
  logic        result_last_o;

  fmadd_scoreboard lanes = new();
  int          lanes_sent = 0;
  int          quiet_pct = 0;  // percent of lanes with no idle gap

  always #6 clk_i = ~clk_i;

  masked_vector_fmadd_lane dut (.*);

  // Run watchdog: far above the slowest correct run of about 1000 lanes.
  initial begin
    #3_000_000;
    $display("masked_vector_fmadd_lane verification failed");
    $finish;
  end

  // Draw an idle gap 0..16; some phases have none at all.
  function automatic int idle_gap();
    if ($urandom_range(99) < quiet_pct) return 0;
    return $urandom_range(16);
  endfunction

  // Hold one lane on the inputs until it transfers; valid drops only in a gap.
  task automatic send_lane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] src, logic act, logic mrg, logic lst);
    int gap;
    gap = idle_gap();
    if (gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    factor_a_i <= a;
    factor_b_i <= b;
    addend_c_i <= c;
    merge_value_i <= src;
    lane_active_i <= act;
    merge_enable_i <= mrg;
    last_lane_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    lanes.note_lane(a, b, c, src, act, mrg, lst);
    lanes_sent++;
  endtask

  // Biased binary32 operand: specials, subnormals, near-overflow, random.
  function automatic logic [31:0] pick_float();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: r[30:0] = 31'd0;
      1: r[30:0] = 31'h7F80_0000;
      2: r[30:23] = 8'hFF;
      3: r[30:23] = 8'd0;
      4: r[30:23] = 8'(124 + $urandom_range(6));
      5: r[30:23] = 8'(230 + $urandom_range(24));
      6: r[30:23] = 8'($urandom_range(30));
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random ready stalls; results checked at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      lanes.check_lane(lane_result_o, result_last_o);
  end

  initial begin
    int stall;
    forever begin
      stall = idle_gap();
      out_ready_i <= (stall == 0);
      @(posedge clk_i);
      if (stall != 0) begin
        repeat (stall - 1) @(posedge clk_i);
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] a, b, c;
    int vec_len;
    int waited;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners.
    send_lane(32'h3F80_0000, 32'h4000_0000, 32'h3F80_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h7F80_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);   // inf*0
    send_lane(32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h7FA0_0001, 32'h7FC0_0002, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);   // sNaN a
    send_lane(32'h3F80_0000, 32'hFF90_0000, 32'h7FC0_0003, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h3F80_0000, 32'h3F80_0000, 32'hFFA0_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);   // overflow
    send_lane(32'h0000_0001, 32'h3F00_0000, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);   // tie to 0
    send_lane(32'h0000_0003, 32'h3F00_0000, 32'h8000_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h0080_0000, 32'h3F00_0000, 32'h0000_0001, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h8000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'h4B80_0000, 32'h3F80_0000, 32'h3F80_0001, 32'h0, 1'b1, 1'b0, 1'b0);
    send_lane(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 1'b1, 1'b1);
    send_lane(32'h1, 32'h2, 32'h3, 32'h7FA0_0000, 1'b0, 1'b1, 1'b0);  // merge keeps sNaN
    send_lane(32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);  // zero masking
    send_lane(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1);
    in_valid_i <= 1'b0;

    // Sender holds off until the pipeline drains.
    while (lanes.pending.size() != 0) @(posedge clk_i);

    // Random vectors; each vector draws either a gappy or a back-to-back phase.
    while (lanes_sent < 930) begin
      quiet_pct = ($urandom_range(3) == 0) ? 100 : 30;
      vec_len = $urandom_range(1, 16);
      for (int i = 0; i < vec_len; i++) begin
        a = pick_float();
        b = pick_float();
        c = pick_float();
        // Some sums land near cancellation.
        if ($urandom_range(7) == 0) c = {~a[31], a[30:0]} ^ 32'($urandom_range(3));
        send_lane(a, b, c, $urandom(), $urandom_range(99) < 80,
                  1'($urandom_range(1)), i == vec_len - 1);
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (lanes.pending.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    $display("covered %0d lanes: special operands, subnormals, overflow, masking",
             lanes_sent);
    $display("results checked %0d, mismatches %0d", lanes.lanes_checked,
             lanes.mismatches);
    if (lanes.mismatches == 0 && lanes.pending.size() == 0) begin
      $display("masked_vector_fmadd_lane verification clean");
    end else begin
      $display("masked_vector_fmadd_lane verification failed");
    end
    $finish;
  end
endmodule
